// ----- hdl/kcal_pkg.sv -----
package kcal_pkg;

  localparam int CODE_DIGITS_DEF = 4;

  localparam int MATRIX_W  = 16;
  localparam int SAMPLE_W  = 12;
  localparam int SECRET_W  = 16;
  localparam int THRESH_W  = 12;
  localparam int TICKS_W   = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [SECRET_W-1:0] SECRET_RST = 16'd4953;
  localparam logic [THRESH_W-1:0] THRESH_RST = 12'd2089;
  localparam logic [TICKS_W-1:0]  TICKS_RST  = 8'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SECRET   = 2'd0,
    REG_THRESH   = 2'd1,
    REG_DEBOUNCE = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KEY_NONE,
    KEY_DIGIT,
    KEY_HASH,
    KEY_OTHER
  } key_kind_t;

  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_DIGIT  = 3'd1,
    ST_DROP   = 3'd2,
    ST_UNLOCK = 3'd3,
    ST_WRONG  = 3'd4,
    ST_SHORT  = 3'd5
  } status_t;

  typedef struct packed {
    logic               key_held;
    logic               deb_active;
    logic [TICKS_W-1:0] deb_count;
    logic               alarm_on;
    logic               error_on;
    logic               stopped;
  } ctrl_t;

  typedef struct packed {
    logic       alarm_led;
    logic       error_led;
    logic       alarm_raised_now;
    status_t    entry_status;
    logic [3:0] echo_digit;
    logic       halted;
  } result_t;

  // keypad layout by bit: 1 2 3 A / 4 5 6 B / 7 8 9 C / * 0 # D
  function automatic key_kind_t key_kind(input logic [3:0] idx);
    key_kind_t k;
    case (idx)
      4'd3, 4'd7, 4'd11, 4'd12, 4'd15: k = KEY_OTHER;
      4'd14:                           k = KEY_HASH;
      default:                         k = KEY_DIGIT;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] key_value(input logic [3:0] idx);
    logic [3:0] v;
    case (idx)
      4'd0:    v = 4'd1;
      4'd1:    v = 4'd2;
      4'd2:    v = 4'd3;
      4'd4:    v = 4'd4;
      4'd5:    v = 4'd5;
      4'd6:    v = 4'd6;
      4'd8:    v = 4'd7;
      4'd9:    v = 4'd8;
      4'd10:   v = 4'd9;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/kcal_in_if.sv -----
interface kcal_in_if import kcal_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MATRIX_W-1:0] key_matrix;
  logic [SAMPLE_W-1:0] level_sample;

  modport source (output valid, key_matrix, level_sample, input ready);
  modport sink   (input valid, key_matrix, level_sample, output ready);
endinterface

// ----- hdl/kcal_out_if.sv -----
interface kcal_out_if;
  logic       valid;
  logic       ready;
  logic       alarm_led;
  logic       error_led;
  logic       alarm_raised_now;
  logic [2:0] entry_status;
  logic [3:0] echo_digit;
  logic       halted;

  modport source (output valid, alarm_led, error_led, alarm_raised_now, entry_status,
                  echo_digit, halted, input ready);
  modport sink   (input valid, alarm_led, error_led, alarm_raised_now, entry_status,
                  echo_digit, halted, output ready);
endinterface

// ----- hdl/keypad_code_alarm_lock.sv -----
// Channel   Dir  Fields                                           Accept
// key_in    in   key_matrix[16], level_sample[12]                 valid & ready
// res_out   out  alarm_led, error_led, alarm_raised_now,          valid & ready
//                entry_status[3], echo_digit[4], halted
// cfg       in   cfg_we, cfg_index[2], cfg_data[16]               cfg_we
//
// One scan word per cycle while res_out is drained; two registers: input register, then the
// decode/debounce/compare logic into the result register.
// Lock state changes when a word leaves the input register for the result register.
// rst (synchronous) empties both stages and loads the default config.
// A stalled result register holds; the input register still takes one word
// behind it, after which key_in.ready drops.
module keypad_code_alarm_lock import kcal_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  kcal_in_if.sink              key_in,
  kcal_out_if.source           res_out
);

  localparam int CNT_W = $clog2(CODE_DIGITS + 1);

  // config registers
  logic [SECRET_W-1:0] secret_code;
  logic [THRESH_W-1:0] alarm_threshold;
  logic [TICKS_W-1:0]  debounce_ticks;

  // input stage
  logic                s1_valid;
  logic [MATRIX_W-1:0] s1_matrix;
  logic [SAMPLE_W-1:0] s1_sample;
  logic                s1_adv;

  // lock state
  ctrl_t                       ctrl;
  ctrl_t                       ctrl_next;
  logic [CNT_W-1:0]            digit_count;
  logic [CNT_W-1:0]            digit_count_next;
  logic [CODE_DIGITS-1:0][3:0] entries;
  logic                        wr_en;
  logic [3:0]                  wr_digit;

  // result stage
  logic    out_valid;
  result_t res;
  result_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      secret_code     <= SECRET_RST;
      alarm_threshold <= THRESH_RST;
      debounce_ticks  <= TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SECRET:   secret_code     <= cfg_data[SECRET_W-1:0];
        REG_THRESH:   alarm_threshold <= cfg_data[THRESH_W-1:0];
        REG_DEBOUNCE: debounce_ticks  <= cfg_data[TICKS_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // word moves on when the result register is empty or being drained
  assign s1_adv       = s1_valid && (!out_valid || res_out.ready);
  assign key_in.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (key_in.ready) begin
      s1_valid <= key_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (key_in.valid && key_in.ready) begin
      s1_matrix <= key_in.key_matrix;
      s1_sample <= key_in.level_sample;
    end
  end

  kcal_core #(.CODE_DIGITS(CODE_DIGITS)) u_core (
    .ctrl            (ctrl),
    .digit_count     (digit_count),
    .entries         (entries),
    .key_matrix      (s1_matrix),
    .level_sample    (s1_sample),
    .secret_code     (secret_code),
    .alarm_threshold (alarm_threshold),
    .debounce_ticks  (debounce_ticks),
    .ctrl_next       (ctrl_next),
    .digit_count_next(digit_count_next),
    .wr_en           (wr_en),
    .wr_digit        (wr_digit),
    .result          (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl        <= '0;
      digit_count <= '0;
    end else if (s1_adv) begin
      ctrl        <= ctrl_next;
      digit_count <= digit_count_next;
    end
  end

  // one lane per code digit; contents only matter once written
  for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_entry
    always_ff @(posedge clk) begin
      if (s1_adv && wr_en && digit_count == CNT_W'(i)) begin
        entries[i] <= wr_digit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= res_next;
    end
  end

  assign res_out.valid            = out_valid;
  assign res_out.alarm_led        = res.alarm_led;
  assign res_out.error_led        = res.error_led;
  assign res_out.alarm_raised_now = res.alarm_raised_now;
  assign res_out.entry_status     = res.entry_status;
  assign res_out.echo_digit       = res.echo_digit;
  assign res_out.halted           = res.halted;

endmodule

// ----- hdl/kcal_core.sv -----
module kcal_core import kcal_pkg::*; #(
  parameter int CODE_DIGITS = CODE_DIGITS_DEF,
  localparam int CNT_W = $clog2(CODE_DIGITS + 1)
) (
  input  ctrl_t                       ctrl,
  input  logic [CNT_W-1:0]            digit_count,
  input  logic [CODE_DIGITS-1:0][3:0] entries,
  input  logic [MATRIX_W-1:0]         key_matrix,
  input  logic [SAMPLE_W-1:0]         level_sample,
  input  logic [SECRET_W-1:0]         secret_code,
  input  logic [THRESH_W-1:0]         alarm_threshold,
  input  logic [TICKS_W-1:0]          debounce_ticks,
  output ctrl_t                       ctrl_next,
  output logic [CNT_W-1:0]            digit_count_next,
  output logic                        wr_en,
  output logic [3:0]                  wr_digit,
  output result_t                     result
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(CODE_DIGITS);

  logic [3:0]             idx;
  logic                   pressed;
  logic                   accepted;
  logic                   raised;
  logic [CODE_DIGITS-1:0] dig_ok;
  logic                   match;
  key_kind_t              kind;
  status_t                status;

  // lowest-numbered key wins
  always_comb begin
    idx = 4'd0;
    for (int i = MATRIX_W - 1; i >= 0; i--) begin
      if (key_matrix[i]) idx = 4'(i);
    end
  end

  assign pressed = |key_matrix;
  assign kind    = key_kind(idx);

  // entry digit i against code nibble CODE_DIGITS-1-i; nibbles past the code read as 0
  for (genvar i = 0; i < CODE_DIGITS; i++) begin : g_cmp
    localparam int NIB = CODE_DIGITS - 1 - i;
    if (NIB < 4) begin : g_in
      assign dig_ok[i] = entries[i] == secret_code[NIB*4 +: 4];
    end else begin : g_out
      assign dig_ok[i] = entries[i] == 4'd0;
    end
  end
  assign match = &dig_ok;

  always_comb begin
    ctrl_next        = ctrl;
    digit_count_next = digit_count;
    wr_en            = 1'b0;
    wr_digit         = key_value(idx);
    raised           = 1'b0;
    accepted         = 1'b0;
    status           = ST_NONE;

    if (!ctrl.stopped) begin
      if (level_sample >= alarm_threshold && !ctrl.alarm_on) begin
        ctrl_next.alarm_on = 1'b1;
        raised             = 1'b1;
      end

      if (ctrl.deb_active && ctrl.deb_count != '1)
        ctrl_next.deb_count = ctrl.deb_count + 1'b1;
      if (pressed && !ctrl.key_held && !ctrl.deb_active) begin
        ctrl_next.deb_active = 1'b1;
        ctrl_next.deb_count  = '0;
      end
      if (ctrl_next.deb_active && ctrl_next.deb_count > debounce_ticks) begin
        ctrl_next.deb_active = 1'b0;
        ctrl_next.key_held   = pressed;
        accepted             = pressed;
      end
      if (!pressed) ctrl_next.key_held = 1'b0;

      if (accepted) begin
        case (kind)
          KEY_DIGIT: begin
            if (digit_count < FULL) begin
              wr_en            = 1'b1;
              digit_count_next = digit_count + 1'b1;
              status           = ST_DIGIT;
            end else begin
              status = ST_DROP;
            end
          end
          KEY_HASH: begin
            if (digit_count == FULL) begin
              if (match && ctrl_next.alarm_on) begin
                ctrl_next.alarm_on = 1'b0;
                ctrl_next.stopped  = 1'b1;
                status             = ST_UNLOCK;
              end else begin
                ctrl_next.error_on = 1'b1;
                status             = ST_WRONG;
              end
            end else begin
              status = ST_SHORT;
            end
            if (!ctrl_next.stopped) digit_count_next = '0;
          end
          default: ;
        endcase
      end
    end

    result.alarm_led        = ctrl_next.alarm_on;
    result.error_led        = ctrl_next.error_on;
    result.alarm_raised_now = raised;
    result.entry_status     = status;
    result.echo_digit       = wr_en ? wr_digit : 4'd0;
    result.halted           = ctrl_next.stopped;
  end

endmodule

// ----- hdl/kcal_checker.sv -----
module kcal_checker import kcal_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       alarm_led,
  input logic       error_led,
  input logic       alarm_raised_now,
  input logic [2:0] entry_status,
  input logic [3:0] echo_digit,
  input logic       halted
);

  logic seen_halt;
  logic seen_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_halt  <= 1'b0;
      seen_error <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_halt  <= seen_halt | halted;
      seen_error <= seen_error | error_led;
    end
  end

  // once unlocked, stays unlocked
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_halt |-> halted)
    else $error("halted dropped after unlock");

  // error LED never clears
  a_error_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_error |-> error_led)
    else $error("error LED cleared");

  // a halted block reports no alarm, no entry status and no echo digit
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted && entry_status != ST_UNLOCK |->
      !alarm_led && !alarm_raised_now && entry_status == ST_NONE && echo_digit == 4'd0)
    else $error("activity while halted");

  // an unlock on the tick the alarm rises clears it again at once
  a_raise_lit: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_raised_now && entry_status != ST_UNLOCK |-> alarm_led)
    else $error("alarm raised but LED off");

  a_echo_only_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_status != ST_DIGIT |-> echo_digit == 4'd0)
    else $error("echo digit without stored digit");

endmodule

bind keypad_code_alarm_lock kcal_checker u_kcal_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (res_out.valid),
  .out_ready       (res_out.ready),
  .alarm_led       (res_out.alarm_led),
  .error_led       (res_out.error_led),
  .alarm_raised_now(res_out.alarm_raised_now),
  .entry_status    (res_out.entry_status),
  .echo_digit      (res_out.echo_digit),
  .halted          (res_out.halted)
);

// ----- bench/keypad_code_alarm_lock_test.sv -----
`timescale 1ns / 100ps

module keypad_code_alarm_lock_test import kcal_pkg::*; ;

  // Stall guard: cycles in which no word moves on either channel.
  localparam int QUIET_LIMIT = 400;
  // Receiver hold-off long enough to back the block up into its input.
  localparam int LONG_HOLD = 40;

  // Key positions in the scan matrix (bit = row*4 + col).
  localparam int LETTER_A_KEY = 3;
  localparam int STAR_KEY     = 12;
  localparam int ZERO_KEY     = 13;
  localparam int HASH_KEY     = 14;
  localparam int LETTER_D_KEY = 15;

  localparam logic [MATRIX_W-1:0] LETTER_A_MASK = MATRIX_W'(1) << LETTER_A_KEY;
  localparam logic [MATRIX_W-1:0] STAR_MASK     = MATRIX_W'(1) << STAR_KEY;
  localparam logic [MATRIX_W-1:0] ZERO_MASK     = MATRIX_W'(1) << ZERO_KEY;
  localparam logic [MATRIX_W-1:0] HASH_MASK     = MATRIX_W'(1) << HASH_KEY;
  localparam logic [MATRIX_W-1:0] LETTER_D_MASK = MATRIX_W'(1) << LETTER_D_KEY;

  typedef struct packed {
    logic [MATRIX_W-1:0] matrix;
    logic [SAMPLE_W-1:0] level;
  } scan_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  cfg_reg_t             cfg_index = REG_SECRET;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic                 drv_valid = 1'b0;
  logic [MATRIX_W-1:0]  drv_matrix = '0;
  logic [SAMPLE_W-1:0]  drv_level = '0;
  logic                 mon_ready = 1'b0;

  kcal_in_if  key_if ();
  kcal_out_if res_if ();

  assign key_if.valid        = drv_valid;
  assign key_if.key_matrix   = drv_matrix;
  assign key_if.level_sample = drv_level;
  assign res_if.ready        = mon_ready;

  keypad_code_alarm_lock dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key_in    (key_if),
    .res_out   (res_if)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the lock: register copies and its internal state.
  // ---------------------------------------------------------------------------
  logic [SECRET_W-1:0] code_setting = SECRET_RST;
  logic [THRESH_W-1:0] alarm_level  = THRESH_RST;
  logic [TICKS_W-1:0]  settle_ticks = TICKS_RST;

  logic                key_down     = 1'b0;  // accepted key still held
  logic                bouncing     = 1'b0;  // debounce count running
  logic [TICKS_W-1:0]  bounce_count = '0;
  logic [3:0]          entry [CODE_DIGITS_DEF];
  int                  entry_len    = 0;
  logic                alarm_on     = 1'b0;
  logic                wrong_seen   = 1'b0;
  logic                unlocked     = 1'b0;

  scan_word_t scan_queue[$];   // words waiting for the driver
  result_t    lock_expect[$];  // predicted results, oldest first

  int scans_queued = 0;
  int results_seen = 0;
  int fails        = 0;
  int idle_pct     = 0;        // chance of an idle burst per free slot; 0 = none
  int level_cap    = 4095;     // highest level sample the generator uses
  int gap_left     = 0;
  int hold_left    = 0;
  int quiet        = 0;

  // One scan tick through the lock; returns the result it should give.
  function automatic result_t lock_tick(input logic [MATRIX_W-1:0] matrix,
                                        input logic [SAMPLE_W-1:0] level);
    result_t    r;
    logic       pressed;
    logic       taken;
    logic       match;
    int         key;
    int         row;
    int         col;
    int         i;
    key_kind_t  kind;
    logic [3:0] digit;
    r = '0;
    if (!unlocked) begin
      pressed = |matrix;
      taken   = 1'b0;
      key     = 0;
      for (i = MATRIX_W - 1; i >= 0; i--) begin
        if (matrix[i]) key = i;
      end

      if (level >= alarm_level && !alarm_on) begin
        alarm_on           = 1'b1;
        r.alarm_raised_now = 1'b1;
      end

      // count first, then a fresh press restarts it, then test for expiry
      if (bouncing && bounce_count != 8'hFF) bounce_count++;
      if (pressed && !key_down && !bouncing) begin
        bouncing     = 1'b1;
        bounce_count = '0;
      end
      if (bouncing && bounce_count > settle_ticks) begin
        bouncing = 1'b0;
        key_down = pressed;
        taken    = pressed;
      end
      if (!pressed) key_down = 1'b0;

      if (taken) begin
        // row/col decode: column 3 is letters, bottom row is * 0 # D
        row   = key / 4;
        col   = key % 4;
        digit = '0;
        if (col == 3) begin
          kind = KEY_OTHER;
        end else if (row < 3) begin
          kind  = KEY_DIGIT;
          digit = 4'(row * 3 + col + 1);
        end else if (col == 1) begin
          kind = KEY_DIGIT;
        end else if (col == 2) begin
          kind = KEY_HASH;
        end else begin
          kind = KEY_OTHER;
        end

        if (kind == KEY_DIGIT) begin
          if (entry_len < CODE_DIGITS_DEF) begin
            entry[entry_len] = digit;
            entry_len++;
            r.entry_status = ST_DIGIT;
            r.echo_digit   = digit;
          end else begin
            r.entry_status = ST_DROP;
          end
        end else if (kind == KEY_HASH) begin
          if (entry_len == CODE_DIGITS_DEF) begin
            match = 1'b1;
            for (i = 0; i < CODE_DIGITS_DEF; i++) begin
              if (entry[i] != code_setting[(CODE_DIGITS_DEF - 1 - i) * 4 +: 4]) match = 1'b0;
            end
            if (match && alarm_on) begin
              alarm_on       = 1'b0;
              unlocked       = 1'b1;
              r.entry_status = ST_UNLOCK;
            end else begin
              wrong_seen     = 1'b1;
              r.entry_status = ST_WRONG;
            end
          end else begin
            r.entry_status = ST_SHORT;
          end
          if (!unlocked) entry_len = 0;
        end
      end
    end
    r.alarm_led = alarm_on;
    r.error_led = wrong_seen;
    r.halted    = unlocked;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. They only fill the queue; the driver paces it.
  // ---------------------------------------------------------------------------
  function automatic void push_scan(input logic [MATRIX_W-1:0] matrix,
                                    input logic [SAMPLE_W-1:0] level);
    scan_word_t w;
    w.matrix = matrix;
    w.level  = level;
    scan_queue.push_back(w);
    scans_queued++;
  endfunction

  // edges of the allowed range turn up often
  function automatic logic [SAMPLE_W-1:0] pick_level();
    int p;
    p = $urandom_range(7);
    if (p == 0) return '0;
    if (p == 1) return SAMPLE_W'(level_cap);
    return SAMPLE_W'($urandom_range(level_cap));
  endfunction

  // key at idx, now and then with higher-numbered keys pressed as well
  function automatic logic [MATRIX_W-1:0] key_mask(input int idx);
    logic [MATRIX_W-1:0] m;
    logic [MATRIX_W-1:0] above;
    m      = '0;
    m[idx] = 1'b1;
    above  = '1 << (idx + 1);
    if ($urandom_range(3) == 0) m = m | (above & 16'($urandom));
    return m;
  endfunction

  function automatic int digit_key(input int d);
    return (d == 0) ? ZERO_KEY : ((d - 1) / 3) * 4 + (d - 1) % 3;
  endfunction

  // long enough to get through the debounce, capped for the very slow setting
  function automatic int press_len();
    return ((settle_ticks > 10) ? 10 : int'(settle_ticks)) + 2 + $urandom_range(2);
  endfunction

  function automatic void tap(input logic [MATRIX_W-1:0] mask, input int hold, input int gap);
    repeat (hold) push_scan(mask, pick_level());
    repeat (gap) push_scan('0, pick_level());
  endfunction

  function automatic logic [SECRET_W-1:0] bcd_code();
    logic [SECRET_W-1:0] c;
    int i;
    for (i = 0; i < 4; i++) c[i * 4 +: 4] = 4'($urandom_range(9));
    return c;
  endfunction

  // a code with one nibble above 9, so no entry can ever match it
  function automatic logic [SECRET_W-1:0] broken_code();
    logic [SECRET_W-1:0] c;
    int n;
    c = bcd_code();
    n = $urandom_range(3);
    c[n * 4 +: 4] = 4'($urandom_range(15, 10));
    return c;
  endfunction

  // Random traffic: mostly clean presses and code attempts, some noise and
  // presses let go before the debounce runs out.
  function automatic void scan_mix(input int n);
    int stop_at;
    int pick;
    int len;
    int k;
    int d;
    logic [3:0] nib;
    stop_at = scans_queued + n;
    while (scans_queued < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        repeat ($urandom_range(3, 1)) push_scan(16'($urandom), pick_level());
      end else if (pick < 45) begin
        len = ($urandom_range(99) < 80) ? 4 : $urandom_range(6);
        for (k = 0; k < len; k++) begin
          nib = (k < 4) ? code_setting[(3 - k) * 4 +: 4] : 4'd0;
          d   = (k < 4 && nib <= 9 && $urandom_range(3) != 0) ? int'(nib) : $urandom_range(9);
          tap(key_mask(digit_key(d)), press_len(), $urandom_range(2, 1));
        end
        tap(key_mask(HASH_KEY), press_len(), $urandom_range(2, 1));
      end else if (pick < 55) begin
        len = $urandom_range((settle_ticks > 5) ? 6 : settle_ticks + 1, 1);
        repeat (len) push_scan(key_mask($urandom_range(15)), pick_level());
        repeat ($urandom_range(3, 1)) push_scan('0, pick_level());
      end else begin
        tap(key_mask($urandom_range(15)), press_len(), $urandom_range(2, 1));
      end
    end
  endfunction

  // Wait until the block is empty: nothing queued, offered or outstanding.
  task automatic settle();
    do @(negedge clk);
    while (scan_queue.size() != 0 || drv_valid || lock_expect.size() != 0);
  endtask

  // Write all three registers back to back while the block is empty.
  task automatic program_lock(input logic [SECRET_W-1:0] code,
                              input logic [THRESH_W-1:0] level,
                              input logic [TICKS_W-1:0] ticks);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SECRET;
    cfg_data  <= code;
    @(posedge clk);
    cfg_index <= REG_THRESH;
    cfg_data  <= CFG_W'(level);
    @(posedge clk);
    cfg_index <= REG_DEBOUNCE;
    cfg_data  <= CFG_W'(ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
    code_setting = code;
    alarm_level  = level;
    settle_ticks = ticks;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued scan words, predicts each one as it is taken.
  // A word once offered stays put until accepted; gaps fall between words.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scan_driver
    scan_word_t w;
    if (rst) begin
      drv_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (drv_valid && key_if.ready) lock_expect.push_back(lock_tick(drv_matrix, drv_level));
      if (!drv_valid || key_if.ready) begin
        if (gap_left > 0) begin
          drv_valid <= 1'b0;
          gap_left--;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          drv_valid <= 1'b0;
          gap_left = $urandom_range(7);
        end else if (scan_queue.size() != 0) begin
          w = scan_queue.pop_front();
          drv_valid  <= 1'b1;
          drv_matrix <= w.matrix;
          drv_level  <= w.level;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: takes results, checks them against the oldest prediction and
  // paces ready. Two long hold-offs let the block back up into its input.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst) begin
      mon_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_if.valid && mon_ready) begin
        results_seen++;
        if (lock_expect.size() == 0) begin
          fails++;
          $display("%0t ns: result expected none, got status %0d digit %0d", $time,
                   res_if.entry_status, res_if.echo_digit);
        end else begin
          want = lock_expect.pop_front();
          check_field("alarm_led", 4'(want.alarm_led), 4'(res_if.alarm_led));
          check_field("error_led", 4'(want.error_led), 4'(res_if.error_led));
          check_field("alarm_raised_now", 4'(want.alarm_raised_now),
                      4'(res_if.alarm_raised_now));
          check_field("entry_status", 4'(want.entry_status), 4'(res_if.entry_status));
          check_field("echo_digit", want.echo_digit, res_if.echo_digit);
          check_field("halted", 4'(want.halted), 4'(res_if.halted));
        end
        if (results_seen == 150 || results_seen == 520) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        mon_ready <= 1'b0;
        hold_left--;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        mon_ready <= 1'b0;
        hold_left = $urandom_range(7);
      end else begin
        mon_ready <= 1'b1;
      end
    end
  end

  // Nothing moving on either side for too long means the block has hung.
  always @(posedge clk) begin : watchdog
    if (rst || (drv_valid && key_if.ready) || (res_if.valid && mon_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("keypad_code_alarm_lock_test: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence. Unlocking halts the lock for good, so the run keeps any
  // valid code away from a raised alarm until the very end:
  //   - valid codes only while the threshold sits above every sample,
  //   - codes with a nibble above 9 once the alarm can rise,
  //   - the real unlock last, followed by a few words that must be ignored.
  // ---------------------------------------------------------------------------
  initial begin : run
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Code 0000, alarm out of reach, quickest debounce.
    program_lock(16'h0000, 12'd4095, 8'd0);
    level_cap = 4094;
    idle_pct  = 25;
    tap(HASH_MASK, 2, 1);                          // hash on empty entry: too few digits
    tap(STAR_MASK | LETTER_D_MASK, 2, 1);          // star wins over D, taken but ignored
    push_scan(LETTER_A_MASK, pick_level());        // let go before the debounce ends
    push_scan('0, pick_level());
    tap(ZERO_MASK, 2, 1);                          // four zeros, lowest key winning
    tap(ZERO_MASK | LETTER_D_MASK, 2, 1);
    tap(ZERO_MASK | HASH_MASK, 2, 1);
    tap(ZERO_MASK | HASH_MASK | LETTER_D_MASK, 2, 1);
    tap('1, 2, 1);                                 // every key: '1', entry full, dropped
    tap(HASH_MASK, 2, 1);                          // right code, no alarm: wrong code
    scan_mix(150);

    // Valid random code, samples kept below the threshold; no idling.
    program_lock(bcd_code(), 12'($urandom_range(4095, 2000)), 8'($urandom_range(3, 1)));
    level_cap = int'(alarm_level) - 1;
    idle_pct  = 0;
    scan_mix(150);

    // Slowest debounce: nothing is ever taken.
    program_lock(16'hFFFF, alarm_level, 8'd255);
    idle_pct = 30;
    scan_mix(40);

    // Full sample range from here on: the alarm comes up and stays.
    program_lock(broken_code(), THRESH_RST, 8'd0);
    level_cap = 4095;
    idle_pct  = 25;
    scan_mix(150);

    // Lowest threshold; last stretch runs with no idling at all.
    program_lock(broken_code(), 12'd0, 8'($urandom_range(4)));
    idle_pct = 0;
    scan_mix(150);

    // Unlock under a raised alarm, then words that a halted lock ignores.
    program_lock(16'h1359, 12'd4095, 8'd0);
    repeat (2) push_scan('0, pick_level());
    tap(HASH_MASK, 2, 1);                          // clears any half-typed entry
    for (k = 0; k < CODE_DIGITS_DEF; k++)
      tap(key_mask(digit_key(int'(code_setting[(3 - k) * 4 +: 4]))), 2, 1);
    tap(HASH_MASK, 2, 1);
    repeat (3) push_scan(16'($urandom), pick_level());

    settle();
    repeat (6) @(posedge clk);
    if (fails == 0) begin
      $display("keypad_code_alarm_lock_test: done, clean");
    end else begin
      $display("keypad_code_alarm_lock_test: done, errors");
    end
    $finish;
  end

endmodule

// ----- keypad_code_alarm_lock.f -----
hdl/kcal_pkg.sv
hdl/kcal_in_if.sv
hdl/kcal_out_if.sv
hdl/kcal_core.sv
hdl/keypad_code_alarm_lock.sv
hdl/kcal_checker.sv
bench/keypad_code_alarm_lock_test.sv
